/* hw/rtl/p2pd_pkg.sv */
// Shared types, result codes and SHA-256 constants for the message deframer.
package p2pd_pkg;

    // Result kinds on the output channel
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [2:0] KIND_OK        = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
    localparam logic [2:0] KIND_TOO_LARGE = 3'd4;
    localparam logic [2:0] KIND_BAD_SUM   = 3'd5;

    // Configuration register indexes
    localparam logic REG_MAGIC       = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    localparam int          HEADER_BYTES    = 24;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd33554432;

    // Operation codes passed from the front to the back
    typedef enum logic [1:0] {
        OP_HDR,
        OP_ERR,
        OP_PAY
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        is_last;
        logic [63:0] head;
        logic [31:0] tail;
        logic [31:0] len;
        logic [31:0] csum;
    } op_t;

    localparam logic [0:7][31:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* hw/rtl/p2pd_front.sv */
// Front end: collects header bytes, checks them and queues operations.
module p2pd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_wr_data,
    input  logic             q_full,
    output logic             q_push,
    output p2pd_pkg::op_t    q_op
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } phase_t;

    localparam logic [4:0] HDR_LAST = 5'(p2pd_pkg::HEADER_BYTES - 1);

    phase_t         phase_reg;
    logic [4:0]     hcnt_reg;
    logic [31:0]    pcnt_reg;
    logic [31:0]    plen_reg;
    logic [183:0]   hdr_reg;
    logic [31:0]    magic_reg;
    logic [31:0]    max_reg;
    logic [191:0]   full_hdr;
    logic [31:0]    pcnt_inc;
    logic           accept;
    logic           hdr_done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign full_hdr = {rx_byte, hdr_reg};
    assign pcnt_inc = pcnt_reg + 32'd1;
    assign hdr_done = (hcnt_reg == HDR_LAST);

    // Classify the accepted item
    always_comb
    begin
        q_push       = 1'b0;
        q_op         = '0;
        q_op.code    = p2pd_pkg::OP_PAY;
        q_op.len     = full_hdr[159:128];
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_done)
                    begin
                        q_push = 1'b1;
                        priority if (full_hdr[31:0] != magic_reg)
                        begin
                            q_op.code = p2pd_pkg::OP_ERR;
                            q_op.kind = p2pd_pkg::KIND_BAD_MAGIC;
                        end
                        else if (full_hdr[159:128] > max_reg)
                        begin
                            q_op.code = p2pd_pkg::OP_ERR;
                            q_op.kind = p2pd_pkg::KIND_TOO_LARGE;
                        end
                        else
                        begin
                            q_op.code = p2pd_pkg::OP_HDR;
                            q_op.kind = p2pd_pkg::KIND_HEADER;
                            q_op.head = full_hdr[95:32];
                            q_op.tail = full_hdr[127:96];
                            q_op.csum = full_hdr[191:160];
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    q_push       = 1'b1;
                    q_op.code    = p2pd_pkg::OP_PAY;
                    q_op.kind    = p2pd_pkg::KIND_PAYLOAD;
                    q_op.data    = rx_byte;
                    q_op.is_last = (pcnt_inc == plen_reg);
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
            max_reg   <= p2pd_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                p2pd_pkg::REG_MAGIC:       magic_reg <= cfg_wr_data;
                p2pd_pkg::REG_MAX_PAYLOAD: max_reg   <= cfg_wr_data;
                default:                   magic_reg <= magic_reg;
            endcase
        end
    end

    // Advance the framing phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            pcnt_reg  <= '0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_reg <= full_hdr[191:8];
                    if (hdr_done)
                    begin
                        hcnt_reg <= '0;
                        pcnt_reg <= '0;
                        plen_reg <= full_hdr[159:128];
                        if (full_hdr[31:0] != magic_reg || full_hdr[159:128] > max_reg)
                        begin
                            phase_reg <= PH_HALTED;
                        end
                        else if (full_hdr[159:128] != 32'd0)
                        begin
                            phase_reg <= PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        hcnt_reg <= hcnt_reg + 5'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    pcnt_reg <= pcnt_inc;
                    if (pcnt_inc == plen_reg)
                    begin
                        phase_reg <= PH_HEADER;
                    end
                end
                default:
                begin
                    phase_reg <= PH_HALTED;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/p2pd_queue.sv */
// Short operation queue between the front and the back.
module p2pd_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  p2pd_pkg::op_t    push_op,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output p2pd_pkg::op_t    head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    p2pd_pkg::op_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_op   = mem[rd_ptr_reg];

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/p2pd_back.sv */
// Back end: emits results, hashes the payload and checks the checksum.
module p2pd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  p2pd_pkg::op_t    q_op,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic [63:0]      command_head,
    output logic [31:0]      command_tail,
    output logic [31:0]      payload_length,
    output logic             last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_SECOND,
        S_INIT,
        S_RND,
        S_ADD,
        S_CHECK
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    logic [0:7][31:0]   st_reg;
    logic [0:7][31:0]   wk_reg;
    logic [511:0]       blk_reg;
    logic [5:0]         pos_reg;
    logic [5:0]         rnd_reg;
    logic [2:0]         lcnt_reg;
    logic [31:0]        len_reg;
    logic [31:0]        csum_reg;
    logic               halted_reg;
    logic               out_valid_reg;
    logic [2:0]         kind_reg;
    logic [7:0]         data_reg;
    logic [63:0]        head_reg;
    logic [31:0]        tail_reg;
    logic [31:0]        plen_reg;
    logic               last_reg;

    logic               out_free;
    logic [31:0]        t1;
    logic [31:0]        t2;
    logic [31:0]        new_w;
    logic [31:0]        w0;
    logic [31:0]        w1;
    logic [31:0]        w9;
    logic [31:0]        w14;
    logic [63:0]        len_bits_sh;
    logic [31:0]        dig_swap;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && (halted_reg || out_free);

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign data_byte      = data_reg;
    assign command_head   = head_reg;
    assign command_tail   = tail_reg;
    assign payload_length = plen_reg;
    assign last           = last_reg;

    // One compression round and the next schedule word
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign t1  = wk_reg[7] + (rotr(wk_reg[4], 6) ^ rotr(wk_reg[4], 11) ^ rotr(wk_reg[4], 25))
               + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
               + p2pd_pkg::SHA_K[rnd_reg] + w0;
    assign t2  = (rotr(wk_reg[0], 2) ^ rotr(wk_reg[0], 13) ^ rotr(wk_reg[0], 22))
               + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
    assign new_w = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    // Length field bytes, most significant first
    assign len_bits_sh = {29'd0, len_reg, 3'd0} << {lcnt_reg, 3'b000};
    assign dig_swap    = {st_reg[0][7:0], st_reg[0][15:8], st_reg[0][23:16], st_reg[0][31:24]};

    // Sequence operations, hashing and result output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            lcnt_reg      <= '0;
            st_reg        <= p2pd_pkg::SHA_IV;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && !halted_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= q_op.kind;
                        data_reg      <= '0;
                        head_reg      <= '0;
                        tail_reg      <= '0;
                        plen_reg      <= q_op.len;
                        last_reg      <= 1'b1;
                        unique case (q_op.code)
                            p2pd_pkg::OP_ERR:
                            begin
                                halted_reg <= 1'b1;
                            end
                            p2pd_pkg::OP_HDR:
                            begin
                                head_reg <= q_op.head;
                                tail_reg <= q_op.tail;
                                len_reg  <= q_op.len;
                                csum_reg <= q_op.csum;
                                st_reg   <= p2pd_pkg::SHA_IV;
                                pos_reg  <= '0;
                                if (q_op.len == 32'd0)
                                begin
                                    last_reg  <= 1'b0;
                                    state_reg <= S_PAD80;
                                end
                            end
                            p2pd_pkg::OP_PAY:
                            begin
                                data_reg <= q_op.data;
                                plen_reg <= '0;
                                last_reg <= !q_op.is_last;
                                blk_reg  <= {blk_reg[503:0], q_op.data};
                                pos_reg  <= pos_reg + 6'd1;
                                if (pos_reg == 6'd63)
                                begin
                                    state_reg <= S_INIT;
                                    ret_reg   <= q_op.is_last ? S_PAD80 : S_IDLE;
                                end
                                else if (q_op.is_last)
                                begin
                                    state_reg <= S_PAD80;
                                end
                            end
                            default:
                            begin
                                halted_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PAD80:
                begin
                    blk_reg <= {blk_reg[503:0], 8'h80};
                    pos_reg <= pos_reg + 6'd1;
                    ret_reg <= S_PADZ;
                    state_reg <= (pos_reg == 6'd63) ? S_INIT : S_PADZ;
                end
                S_PADZ:
                begin
                    if (pos_reg == 6'd56)
                    begin
                        lcnt_reg  <= '0;
                        state_reg <= S_PADLEN;
                    end
                    else
                    begin
                        blk_reg <= {blk_reg[503:0], 8'h00};
                        pos_reg <= pos_reg + 6'd1;
                        ret_reg <= S_PADZ;
                        if (pos_reg == 6'd63)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_PADLEN:
                begin
                    blk_reg  <= {blk_reg[503:0], len_bits_sh[63:56]};
                    pos_reg  <= pos_reg + 6'd1;
                    lcnt_reg <= lcnt_reg + 3'd1;
                    if (lcnt_reg == 3'd7)
                    begin
                        ret_reg   <= S_SECOND;
                        state_reg <= S_INIT;
                    end
                end
                S_SECOND:
                begin
                    // Hash the 32-byte digest again, padding is fixed
                    blk_reg   <= {st_reg, 8'h80, 184'd0, 64'd256};
                    st_reg    <= p2pd_pkg::SHA_IV;
                    ret_reg   <= S_CHECK;
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    wk_reg    <= st_reg;
                    rnd_reg   <= '0;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    wk_reg  <= {t1 + t2, wk_reg[0], wk_reg[1], wk_reg[2],
                                wk_reg[3] + t1, wk_reg[4], wk_reg[5], wk_reg[6]};
                    blk_reg <= {blk_reg[479:0], new_w};
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        st_reg[i] <= st_reg[i] + wk_reg[i];
                    end
                    state_reg <= ret_reg;
                end
                S_CHECK:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        data_reg      <= '0;
                        head_reg      <= '0;
                        tail_reg      <= '0;
                        plen_reg      <= len_reg;
                        last_reg      <= 1'b1;
                        if (csum_reg == dig_swap)
                        begin
                            kind_reg <= p2pd_pkg::KIND_OK;
                        end
                        else
                        begin
                            kind_reg   <= p2pd_pkg::KIND_BAD_SUM;
                            halted_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/p2p_message_deframer_top.sv */
// Receive-side message deframer: header checks, payload pass-through, checksum.
//
// Input channel in_valid/in_ready/rx_byte carries the received stream, one byte
// per item. Output channel out_valid/out_ready carries results: header, payload
// bytes, then an ok or bad-checksum status; last marks the final result that an
// input byte causes. Write magic_word (index 0) and max_payload (index 1) through
// cfg_wr_en/cfg_index/cfg_wr_data while the block is idle.
// Header bytes are accepted while the queue is not full; the first result of a
// byte passes through the operation queue and then the output register. A payload
// byte is shifted into the block in the back end; each 64-byte block is compressed
// by the single round unit (load, 64 rounds, add), and meanwhile no new operation
// leaves the queue. The end of a message takes padding (0x80, zeros, the 64-bit
// length) plus two or three compressions before the status appears.
// An operation queue between front and back lets header bytes keep arriving
// while the back end hashes. A stalled receiver holds the output register; the
// queue then fills and in_ready drops. Payload is passed out before the status,
// so the receiver keeps it until the status arrives. Any error halts the block:
// further bytes are accepted and dropped. Reset clears FSM state; no clear pass.
module p2p_message_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [63:0] command_head,
    output logic [31:0] command_tail,
    output logic [31:0] payload_length,
    output logic        last
);

    p2pd_pkg::op_t push_op;
    p2pd_pkg::op_t head_op;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_valid;

    p2pd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    p2pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (push_op),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_op   (head_op)
    );

    p2pd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_op           (head_op),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .command_head   (command_head),
        .command_tail   (command_tail),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

/* hw/rtl/p2pd_checker.sv */
// Port-level checks on the deframer results, bound to the top level.
module p2pd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  data_byte,
    input logic [31:0] payload_length,
    input logic        last
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte))
        else $error("stalled output item changed");

    // Drive data only for payload bytes
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != p2pd_pkg::KIND_PAYLOAD |-> data_byte == 8'd0)
        else $error("data byte set on non-payload item");

    // Drop length on payload bytes
    a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == p2pd_pkg::KIND_PAYLOAD |-> payload_length == 32'd0)
        else $error("length set on payload item");

    // Close every status item, ok or error, with last
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == p2pd_pkg::KIND_BAD_MAGIC || kind == p2pd_pkg::KIND_TOO_LARGE
        || kind == p2pd_pkg::KIND_BAD_SUM || kind == p2pd_pkg::KIND_OK) |-> last)
        else $error("status item without last");

endmodule

bind p2p_message_deframer_top p2pd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .last           (last)
);
